FILE: rtl/bovs_pkg.sv
// ----------------------------------------------------------------------------
// bovs_pkg
// Shared types and constants for the best-overlap box selector: register
// indexes, fixed field widths and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package bovs_pkg;

    // fixed field widths
    localparam int RATIO_BITS    = 17;
    localparam int FRAC_BITS     = 16;
    localparam int SCORE_BITS    = 16;
    localparam int INDEX_BITS    = 12;
    localparam int CFG_ADDR_BITS = 2;

    // divider runs one quotient bit per step
    localparam int DIV_STEPS    = RATIO_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // target box reset size
    localparam int TARGET_W_RESET = 100;
    localparam int TARGET_H_RESET = 40;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_TARGET_X = 2'd0,
        CFG_TARGET_Y = 2'd1,
        CFG_TARGET_W = 2'd2,
        CFG_TARGET_H = 2'd3
    } bovs_cfg_reg_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic area_en;
        logic union_en;
        logic prod_en;
        logic decide_en;
        logic div_start;
        logic div_step;
        logic emit;
    } bovs_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last;
        logic div_last;
    } bovs_status_t;

endpackage

FILE: rtl/bovs_div.sv
// ----------------------------------------------------------------------------
// bovs_div
// Restoring divider for the final ratio: (inter * 2^16 + union / 2) / union,
// one quotient bit per step, 17 steps.
// ----------------------------------------------------------------------------
module bovs_div #(
    parameter int AREA_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic                           step,
    input  logic [AREA_BITS-1:0]           inter,
    input  logic [AREA_BITS:0]             uni,
    output logic [bovs_pkg::RATIO_BITS-1:0] quotient,
    output logic                           last_step
);
    import bovs_pkg::*;

    localparam int NUM_BITS = AREA_BITS + RATIO_BITS;

    logic [AREA_BITS:0]          den_reg;
    logic [AREA_BITS:0]          rem_reg;
    logic [RATIO_BITS-1:0]       sh_reg;
    logic [DIV_CNT_BITS-1:0]     cnt_reg;
    logic [NUM_BITS-1:0]         num;
    logic [AREA_BITS+1:0]        trial;
    logic [AREA_BITS+1:0]        diff;
    logic                        ge;

    // rounded numerator; quotient never exceeds 2^16 so the top part is below union
    assign num = {1'b0, inter, {FRAC_BITS{1'b0}}} + NUM_BITS'(uni >> 1);

    // one trial subtraction
    assign trial = {rem_reg, sh_reg[RATIO_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    assign quotient  = sh_reg;
    assign last_step = (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1));

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= '0;
        end else if (step) begin
            cnt_reg <= cnt_reg + DIV_CNT_BITS'(1);
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= uni;
            rem_reg <= {1'b0, num[NUM_BITS-1:RATIO_BITS]};
            sh_reg  <= num[RATIO_BITS-1:0];
        end else if (step) begin
            rem_reg <= ge ? diff[AREA_BITS:0] : trial[AREA_BITS:0];
            sh_reg  <= {sh_reg[RATIO_BITS-2:0], ge};
        end
    end

endmodule

FILE: rtl/bovs_datapath.sv
// ----------------------------------------------------------------------------
// bovs_datapath
// Target registers, per-box area and union arithmetic, cross-multiplied
// compare against the kept best, tracking state and the result register.
// ----------------------------------------------------------------------------
module bovs_datapath #(
    parameter int COORD_BITS = 12,
    parameter int MAX_BOXES  = 4096
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [bovs_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [COORD_BITS-1:0]                  cfg_wdata,
    input  logic [COORD_BITS-1:0]                  in_left,
    input  logic [COORD_BITS-1:0]                  in_top,
    input  logic [COORD_BITS-1:0]                  in_right,
    input  logic [COORD_BITS-1:0]                  in_bottom,
    input  logic signed [bovs_pkg::SCORE_BITS-1:0] in_score,
    input  logic                                   in_last,
    input  bovs_pkg::bovs_cmd_t                    cmd,
    output bovs_pkg::bovs_status_t                 status,
    output logic [bovs_pkg::RATIO_BITS-1:0]        best_ratio,
    output logic signed [bovs_pkg::SCORE_BITS-1:0] best_score,
    output logic [COORD_BITS-1:0]                  best_left,
    output logic [COORD_BITS-1:0]                  best_top,
    output logic [COORD_BITS-1:0]                  best_right,
    output logic [COORD_BITS-1:0]                  best_bottom,
    output logic [bovs_pkg::INDEX_BITS-1:0]        best_index
);
    import bovs_pkg::*;

    localparam int C         = COORD_BITS;
    localparam int AREA_BITS = 2 * C;
    localparam int UNI_BITS  = AREA_BITS + 1;
    localparam int PROD_BITS = AREA_BITS + UNI_BITS;
    localparam int CNT_BITS  = (MAX_BOXES > 2) ? $clog2(MAX_BOXES) : 1;

    // target registers
    logic [C-1:0] tgt_x_reg, tgt_y_reg, tgt_w_reg, tgt_h_reg;

    // latched input item
    logic [C-1:0]            l_reg, t_reg, r_reg, b_reg;
    logic signed [SCORE_BITS-1:0] score_reg;
    logic                    last_reg;

    // area stage
    logic [C:0]              tgt_r, tgt_b;
    logic [C-1:0]            il, ir, it, ib;
    logic [C-1:0]            wc, hc, wi, hi;
    logic [AREA_BITS-1:0]    area_c_reg, inter_reg, area_t_reg;

    // union stage
    logic [UNI_BITS-1:0]     uni_sum;
    logic [AREA_BITS-1:0]    inter_z_reg;
    logic [UNI_BITS-1:0]     uni_reg;

    // cross products
    logic [PROD_BITS-1:0]    p_new_reg, p_best_reg;
    logic                    take;

    // tracking state
    logic                    have_best_reg;
    logic [AREA_BITS-1:0]    best_inter_reg;
    logic [UNI_BITS-1:0]     best_uni_reg;
    logic signed [SCORE_BITS-1:0] kept_score_reg;
    logic [C-1:0]            kept_l_reg, kept_t_reg, kept_r_reg, kept_b_reg;
    logic [INDEX_BITS-1:0]   kept_index_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [CNT_BITS+INDEX_BITS-1:0] cnt_wide;

    // result register
    logic [RATIO_BITS-1:0]   out_ratio_reg;
    logic signed [SCORE_BITS-1:0] out_score_reg;
    logic [C-1:0]            out_l_reg, out_t_reg, out_r_reg, out_b_reg;
    logic [INDEX_BITS-1:0]   out_index_reg;

    logic [RATIO_BITS-1:0]   quotient;
    logic                    div_last;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
            tgt_w_reg <= C'(TARGET_W_RESET);
            tgt_h_reg <= C'(TARGET_H_RESET);
        end else if (cfg_wr_en) begin
            unique case (bovs_cfg_reg_t'(cfg_addr))
                CFG_TARGET_X: tgt_x_reg <= cfg_wdata;
                CFG_TARGET_Y: tgt_y_reg <= cfg_wdata;
                CFG_TARGET_W: tgt_w_reg <= cfg_wdata;
                CFG_TARGET_H: tgt_h_reg <= cfg_wdata;
                default:      tgt_x_reg <= tgt_x_reg;
            endcase
        end
    end

    // latch the accepted request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            l_reg     <= in_left;
            t_reg     <= in_top;
            r_reg     <= in_right;
            b_reg     <= in_bottom;
            score_reg <= in_score;
            last_reg  <= in_last;
        end
    end

    // spans of the candidate and of the intersection; inverted spans are zero
    always_comb begin
        tgt_r = {1'b0, tgt_x_reg} + {1'b0, tgt_w_reg};
        tgt_b = {1'b0, tgt_y_reg} + {1'b0, tgt_h_reg};
        il    = (l_reg > tgt_x_reg) ? l_reg : tgt_x_reg;
        it    = (t_reg > tgt_y_reg) ? t_reg : tgt_y_reg;
        ir    = ({1'b0, r_reg} < tgt_r) ? r_reg : tgt_r[C-1:0];
        ib    = ({1'b0, b_reg} < tgt_b) ? b_reg : tgt_b[C-1:0];
        wc    = (r_reg > l_reg) ? (r_reg - l_reg) : '0;
        hc    = (b_reg > t_reg) ? (b_reg - t_reg) : '0;
        wi    = (ir > il) ? (ir - il) : '0;
        hi    = (ib > it) ? (ib - it) : '0;
    end

    // area products
    always_ff @(posedge aclk) begin
        if (cmd.area_en) begin
            area_c_reg <= {{C{1'b0}}, wc} * {{C{1'b0}}, hc};
            inter_reg  <= {{C{1'b0}}, wi} * {{C{1'b0}}, hi};
            area_t_reg <= {{C{1'b0}}, tgt_w_reg} * {{C{1'b0}}, tgt_h_reg};
        end
    end

    // union; a zero union counts as 0 over 1
    assign uni_sum = {1'b0, area_c_reg} + {1'b0, area_t_reg} - {1'b0, inter_reg};

    always_ff @(posedge aclk) begin
        if (cmd.union_en) begin
            if (uni_sum == '0) begin
                inter_z_reg <= '0;
                uni_reg     <= UNI_BITS'(1);
            end else begin
                inter_z_reg <= inter_reg;
                uni_reg     <= uni_sum;
            end
        end
    end

    // cross products against the kept best
    always_ff @(posedge aclk) begin
        if (cmd.prod_en) begin
            p_new_reg  <= {{UNI_BITS{1'b0}}, inter_z_reg} * {{AREA_BITS{1'b0}}, best_uni_reg};
            p_best_reg <= {{UNI_BITS{1'b0}}, best_inter_reg} * {{AREA_BITS{1'b0}}, uni_reg};
        end
    end

    assign take     = !have_best_reg || (p_new_reg > p_best_reg);
    assign cnt_wide = {{INDEX_BITS{1'b0}}, cnt_reg};

    // tracking control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg <= 1'b0;
            cnt_reg       <= '0;
        end else if (cmd.emit) begin
            have_best_reg <= 1'b0;
            cnt_reg       <= '0;
        end else if (cmd.decide_en) begin
            if (take) begin
                have_best_reg <= 1'b1;
            end
            if (cnt_reg == CNT_BITS'(MAX_BOXES - 1)) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end
        end
    end

    // kept best payload
    always_ff @(posedge aclk) begin
        if (cmd.decide_en && take) begin
            best_inter_reg <= inter_z_reg;
            best_uni_reg   <= uni_reg;
            kept_score_reg <= score_reg;
            kept_l_reg     <= l_reg;
            kept_t_reg     <= t_reg;
            kept_r_reg     <= r_reg;
            kept_b_reg     <= b_reg;
            kept_index_reg <= cnt_wide[INDEX_BITS-1:0];
        end
    end

    // final ratio divider
    bovs_div #(
        .AREA_BITS (AREA_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .step      (cmd.div_step),
        .inter     (best_inter_reg),
        .uni       (best_uni_reg),
        .quotient  (quotient),
        .last_step (div_last)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_ratio_reg <= quotient;
            out_score_reg <= kept_score_reg;
            out_l_reg     <= kept_l_reg;
            out_t_reg     <= kept_t_reg;
            out_r_reg     <= kept_r_reg;
            out_b_reg     <= kept_b_reg;
            out_index_reg <= kept_index_reg;
        end
    end

    assign status.last     = last_reg;
    assign status.div_last = div_last;

    assign best_ratio  = out_ratio_reg;
    assign best_score  = out_score_reg;
    assign best_left   = out_l_reg;
    assign best_top    = out_t_reg;
    assign best_right  = out_r_reg;
    assign best_bottom = out_b_reg;
    assign best_index  = out_index_reg;

endmodule

FILE: rtl/bovs_ctrl.sv
// ----------------------------------------------------------------------------
// bovs_ctrl
// Sequencer: accepts one request, walks it through the area, union, product
// and decide steps, runs the divider at the end of a set, and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module bovs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  bovs_pkg::bovs_status_t status,
    output bovs_pkg::bovs_cmd_t    cmd
);
    import bovs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_UNION,
        ST_PROD,
        ST_DECIDE,
        ST_DINIT,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_AREA;
                end
            end
            ST_AREA: begin
                cmd.area_en = 1'b1;
                state_next  = ST_UNION;
            end
            ST_UNION: begin
                cmd.union_en = 1'b1;
                state_next   = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod_en = 1'b1;
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide_en = 1'b1;
                state_next    = status.last ? ST_DINIT : ST_IDLE;
            end
            ST_DINIT: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

FILE: rtl/best_overlap_box_select.sv
// ----------------------------------------------------------------------------
// best_overlap_box_select
// Finds the candidate box of a set with the best intersection over union
// against a programmable target box.
// ----------------------------------------------------------------------------
// Candidate boxes arrive on the s_ stream, one request per box, with s_tlast
// set on the final box of a set. Each box is compared with the target set by
// the cfg_ write port (x, y, width, height); the best ratio is tracked, an
// equal ratio keeps the earlier box.
// A box is accepted, then passes through area products, union, the two
// cross products and the compare, each a registered step of the datapath.
// After the box marked last, a restoring divider produces the Q1.16 ratio
// one bit per cycle (17 steps plus a load), then the result register is
// loaded.
// One result per set appears on the m_ stream and is held in an output
// register; further boxes are accepted while it waits. If the receiver stalls
// and a second set finishes, that set waits before its result load and s_tready
// stays low until the first result is taken.
// Reset restores the target to 0, 0, 100 by 40 and clears set tracking.
// ----------------------------------------------------------------------------
module best_overlap_box_select #(
    parameter int COORD_BITS = 12,
    parameter int MAX_BOXES  = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [bovs_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COORD_BITS-1:0]              cfg_wdata,
    // candidate stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // box_left, box_top, box_right, box_bottom, box_score, zero pad
    input  logic [((4*COORD_BITS+bovs_pkg::SCORE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                               s_tlast,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // best_ratio, best_score, best_left, best_top, best_right, best_bottom,
    // best_index, zero pad
    output logic [((bovs_pkg::RATIO_BITS+bovs_pkg::SCORE_BITS+4*COORD_BITS
                    +bovs_pkg::INDEX_BITS+7)/8)*8-1:0] m_tdata
);
    import bovs_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int IN_SCORE = 4 * C;
    localparam int OUT_SC   = RATIO_BITS;
    localparam int OUT_L    = OUT_SC + SCORE_BITS;
    localparam int OUT_T    = OUT_L + C;
    localparam int OUT_R    = OUT_T + C;
    localparam int OUT_B    = OUT_R + C;
    localparam int OUT_IDX  = OUT_B + C;

    bovs_cmd_t    cmd;
    bovs_status_t status;

    logic [RATIO_BITS-1:0]        best_ratio;
    logic signed [SCORE_BITS-1:0] best_score;
    logic [C-1:0]                 best_left, best_top, best_right, best_bottom;
    logic [INDEX_BITS-1:0]        best_index;

    // sequencer
    bovs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and tracking
    bovs_datapath #(
        .COORD_BITS (COORD_BITS),
        .MAX_BOXES  (MAX_BOXES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_left     (s_tdata[C-1:0]),
        .in_top      (s_tdata[2*C-1:C]),
        .in_right    (s_tdata[3*C-1:2*C]),
        .in_bottom   (s_tdata[4*C-1:3*C]),
        .in_score    (s_tdata[IN_SCORE+SCORE_BITS-1:IN_SCORE]),
        .in_last     (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .best_ratio  (best_ratio),
        .best_score  (best_score),
        .best_left   (best_left),
        .best_top    (best_top),
        .best_right  (best_right),
        .best_bottom (best_bottom),
        .best_index  (best_index)
    );

    // pack the result
    always_comb begin
        m_tdata                              = '0;
        m_tdata[RATIO_BITS-1:0]              = best_ratio;
        m_tdata[OUT_L-1:OUT_SC]              = best_score;
        m_tdata[OUT_T-1:OUT_L]               = best_left;
        m_tdata[OUT_R-1:OUT_T]               = best_top;
        m_tdata[OUT_B-1:OUT_R]               = best_right;
        m_tdata[OUT_IDX-1:OUT_B]             = best_bottom;
        m_tdata[OUT_IDX+INDEX_BITS-1:OUT_IDX] = best_index;
    end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for best_overlap_box_select: candidate boxes are streamed
// in sets against a series of target boxes, and each set's result is compared
// field by field with a behavioral model of the best-overlap selection.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bovs_pkg::*;

    localparam int CW          = 12;
    localparam int S_BITS      = ((4*CW+SCORE_BITS+7)/8)*8;
    localparam int M_BITS      = ((RATIO_BITS+SCORE_BITS+4*CW+INDEX_BITS+7)/8)*8;
    localparam int HOLD_CYCLES = 64;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_BOXES = 1000;

    typedef struct packed {
        logic [CW-1:0]         left;
        logic [CW-1:0]         top;
        logic [CW-1:0]         right;
        logic [CW-1:0]         bottom;
        logic [SCORE_BITS-1:0] score;
        logic                  last;
    } cand_t;

    typedef struct packed {
        logic [RATIO_BITS-1:0] ratio;
        logic [SCORE_BITS-1:0] score;
        logic [CW-1:0]         left;
        logic [CW-1:0]         top;
        logic [CW-1:0]         right;
        logic [CW-1:0]         bottom;
        logic [INDEX_BITS-1:0] index;
    } best_t;

    typedef enum logic {ROW_BOX, ROW_TARGET} row_kind_t;

    typedef struct {
        row_kind_t kind;
        cand_t     cand;   // for a target row: x, y, width, height in the coordinates
        bit        typed;
        best_t     want;
    } row_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    bovs_cfg_reg_t      cfg_addr  = CFG_TARGET_X;
    logic [CW-1:0]      cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [S_BITS-1:0]  s_tdata   = '0;
    logic               s_tlast   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [M_BITS-1:0]  m_tdata;

    // target box as programmed
    logic [CW-1:0] tgt_x = '0, tgt_y = '0, tgt_w = 12'd100, tgt_h = 12'd40;

    // running best of the current set
    bit                    run_valid = 0;
    logic [63:0]           run_inter = '0, run_union = '0;
    cand_t                 run_box   = '0;
    logic [INDEX_BITS-1:0] run_index = '0, run_count = '0;

    best_t pending_best[$];
    row_t  rows[$];
    int    mismatch_count = 0;
    int    cycle_count    = 0;
    bit    rx_throttle    = 0;
    int    rx_hold        = 0;

    best_overlap_box_select i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_best.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] extent(logic [63:0] lo, logic [63:0] hi);
        return (hi > lo) ? hi - lo : 64'd0;
    endfunction

    // fold one candidate into the running best; a last box yields the set result
    task automatic score_box_against_target(input cand_t c, output bit emits,
                                            output best_t res);
        logic [63:0] tr, tb, area_c, area_t, il, ir, it, ib, inter, uni, ratio;
        bit take;
        tr     = 64'(tgt_x) + 64'(tgt_w);
        tb     = 64'(tgt_y) + 64'(tgt_h);
        area_c = extent(64'(c.left), 64'(c.right)) * extent(64'(c.top), 64'(c.bottom));
        area_t = 64'(tgt_w) * 64'(tgt_h);
        il     = (c.left > tgt_x) ? 64'(c.left) : 64'(tgt_x);
        ir     = (64'(c.right) < tr) ? 64'(c.right) : tr;
        it     = (c.top > tgt_y) ? 64'(c.top) : 64'(tgt_y);
        ib     = (64'(c.bottom) < tb) ? 64'(c.bottom) : tb;
        inter  = extent(il, ir) * extent(it, ib);
        uni    = area_c + area_t - inter;
        // empty union counts as ratio zero
        if (uni == 64'd0) begin
            inter = 64'd0;
            uni   = 64'd1;
        end
        take = !run_valid || (inter * run_union > run_inter * uni);
        if (take) begin
            run_valid = 1;
            run_inter = inter;
            run_union = uni;
            run_box   = c;
            run_index = run_count;
        end
        run_count = run_count + 1'b1;
        emits = c.last;
        res   = '0;
        if (c.last) begin
            ratio = ((run_inter << 16) + (run_union >> 1)) / run_union;
            if (ratio > 64'd65536)
                ratio = 64'd65536;
            res.ratio  = ratio[RATIO_BITS-1:0];
            res.score  = run_box.score;
            res.left   = run_box.left;
            res.top    = run_box.top;
            res.right  = run_box.right;
            res.bottom = run_box.bottom;
            res.index  = run_index;
            run_valid  = 0;
            run_inter  = '0;
            run_union  = '0;
            run_box    = '0;
            run_index  = '0;
            run_count  = '0;
        end
    endtask

    // one request on the candidate stream; starts and ends at a falling edge
    task automatic send_box(input cand_t c, input int gap, input bit typed,
                            input best_t want);
        bit    emits;
        best_t res;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.score, c.bottom, c.right, c.top, c.left};
        s_tlast  <= c.last;
        do @(posedge aclk); while (!s_tready);
        score_box_against_target(c, emits, res);
        if (emits)
            pending_best.insert(pending_best.size(), typed ? want : res);
        @(negedge aclk);
    endtask

    // idle the sender until every result is in, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_best.size() != 0) @(posedge aclk);
        repeat (HOLD_CYCLES) @(negedge aclk);
    endtask

    task automatic set_target(input logic [CW-1:0] x, y, w, h);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_TARGET_X;
        cfg_wdata <= x;
        @(negedge aclk);
        cfg_addr  <= CFG_TARGET_Y;
        cfg_wdata <= y;
        @(negedge aclk);
        cfg_addr  <= CFG_TARGET_W;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_addr  <= CFG_TARGET_H;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tgt_x = x;
        tgt_y = y;
        tgt_w = w;
        tgt_h = h;
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 19);
        if (p < 11)
            return 0;
        else if (p < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CW-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return 12'd4095;
        return v[CW-1:0];
    endfunction

    // candidate jittered around the target
    function automatic cand_t near_target();
        cand_t c;
        int sx, sy, l, t;
        sx = int'(tgt_w) / 2 + 8;
        sy = int'(tgt_h) / 2 + 8;
        l = int'(tgt_x) + int'($urandom_range(0, 2*sx)) - sx;
        t = int'(tgt_y) + int'($urandom_range(0, 2*sy)) - sy;
        c.left   = clamp_coord(l);
        c.top    = clamp_coord(t);
        c.right  = clamp_coord(l + int'(tgt_w) + int'($urandom_range(0, 2*sx)) - sx);
        c.bottom = clamp_coord(t + int'(tgt_h) + int'($urandom_range(0, 2*sy)) - sy);
        c.score  = 16'($urandom);
        c.last   = 1'b0;
        return c;
    endfunction

    function automatic row_t box_row(int l, int t, int r, int b, int score, bit last);
        row_t row;
        row.kind  = ROW_BOX;
        row.cand  = {l[CW-1:0], t[CW-1:0], r[CW-1:0], b[CW-1:0], score[15:0], last};
        row.typed = 0;
        row.want  = '0;
        return row;
    endfunction

    function automatic row_t target_row(int x, int y, int w, int h);
        row_t row;
        row = box_row(x, y, w, h, 0, 0);
        row.kind = ROW_TARGET;
        return row;
    endfunction

    function automatic row_t with_result(row_t row, int ratio, int score, int l, int t,
                                         int r, int b, int index);
        row.typed = 1;
        row.want  = {ratio[RATIO_BITS-1:0], score[15:0], l[CW-1:0], t[CW-1:0],
                     r[CW-1:0], b[CW-1:0], index[INDEX_BITS-1:0]};
        return row;
    endfunction

    // append one row to the directed table
    function automatic void add_row(row_t row);
        rows.insert(rows.size(), row);
    endfunction

    // receiver pacing
    always @(negedge aclk) begin : rx_pace
        int p;
        p = $urandom_range(0, 9);
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (!rx_throttle) begin
            m_tready <= 1'b1;
        end else if (p < 7) begin
            m_tready <= 1'b1;
            rx_hold  <= $urandom_range(0, 4);
        end else if (p < 9) begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(10, 40);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // compare each result request with the oldest expected set result
    always @(posedge aclk) begin : result_check
        best_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RATIO_BITS+SCORE_BITS+4*CW+INDEX_BITS-1:0];
            got = {m_tdata[RATIO_BITS-1:0],
                   m_tdata[RATIO_BITS +: SCORE_BITS],
                   m_tdata[RATIO_BITS+SCORE_BITS +: CW],
                   m_tdata[RATIO_BITS+SCORE_BITS+CW +: CW],
                   m_tdata[RATIO_BITS+SCORE_BITS+2*CW +: CW],
                   m_tdata[RATIO_BITS+SCORE_BITS+3*CW +: CW],
                   m_tdata[RATIO_BITS+SCORE_BITS+4*CW +: INDEX_BITS]};
            if (pending_best.size() == 0) begin
                $display("%0t: unexpected result, expected none, got ratio %0d index %0d",
                         $time, got.ratio, got.index);
                mismatch_count++;
            end else begin
                want = pending_best.pop_front();
                check_field("best_ratio", longint'(want.ratio), longint'(got.ratio));
                check_field("best_score", longint'($signed(want.score)),
                            longint'($signed(got.score)));
                check_field("best_left", longint'(want.left), longint'(got.left));
                check_field("best_top", longint'(want.top), longint'(got.top));
                check_field("best_right", longint'(want.right), longint'(got.right));
                check_field("best_bottom", longint'(want.bottom), longint'(got.bottom));
                check_field("best_index", longint'(want.index), longint'(got.index));
            end
        end
    end

    initial begin : stimulus
        cand_t c, prev;
        int    sent, set_len, phase, phase_sent, k;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed sets, reset target 0,0 100 by 40
        add_row(with_result(box_row(0, 0, 100, 40, 'h7fff, 1),
                            65536, 'h7fff, 0, 0, 100, 40, 0));
        // inverted box
        add_row(with_result(box_row(100, 40, 0, 0, 'h8000, 1),
                            0, 'h8000, 100, 40, 0, 0, 0));
        // first box taken at ratio zero, then a half overlap, then an equal one
        add_row(box_row(4095, 4095, 4095, 4095, 'h0001, 0));
        add_row(box_row(0, 0, 50, 40, 'h0100, 0));
        add_row(with_result(box_row(50, 0, 100, 40, 'hff00, 1),
                            32768, 'h0100, 0, 0, 50, 40, 1));
        // crossing overlap and the full frame
        add_row(box_row(50, 20, 150, 60, 'h1234, 1));
        add_row(box_row(0, 0, 4095, 4095, 'h0000, 1));
        add_row(target_row(0, 0, 4095, 4095));
        add_row(with_result(box_row(0, 0, 4095, 4095, 'hffff, 1),
                            65536, 'hffff, 0, 0, 4095, 4095, 0));
        add_row(box_row(0, 0, 4095, 4094, 'h0a0a, 0));
        add_row(box_row(1, 0, 4095, 4095, 'h0b0b, 1));
        // empty target and empty box: zero union
        add_row(target_row(4095, 4095, 0, 0));
        add_row(with_result(box_row(0, 0, 0, 0, 'h5a5a, 1),
                            0, 'h5a5a, 0, 0, 0, 0, 0));
        add_row(box_row(4095, 0, 0, 4095, 'h1111, 0));
        add_row(with_result(box_row(0, 0, 0, 0, 'h2222, 1),
                            0, 'h1111, 4095, 0, 0, 4095, 0));
        // rounding tie: one pixel in a 2^17 pixel target rounds up
        add_row(target_row(0, 0, 512, 256));
        add_row(with_result(box_row(0, 0, 1, 1, 'h0080, 1),
                            1, 'h0080, 0, 0, 1, 1, 0));
        add_row(box_row(600, 300, 700, 400, 'h3333, 0));
        add_row(box_row(256, 128, 768, 384, 'h4444, 1));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_TARGET)
                set_target(rows[i].cand.left, rows[i].cand.top,
                           rows[i].cand.right, rows[i].cand.bottom);
            else
                send_box(rows[i].cand, pick_gap(), rows[i].typed, rows[i].want);
        end

        // random sets over a series of targets
        sent  = 0;
        phase = 0;
        prev  = '0;
        while (sent < RANDOM_BOXES) begin
            case (phase)
                0: set_target(0, 0, 100, 40);
                1: set_target(0, 0, 4095, 4095);
                2: set_target(4095, 4095, 4095, 4095);
                3: set_target(0, 0, 0, 0);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        set_target(12'($urandom), 12'($urandom), 12'($urandom),
                                   12'($urandom));
                    else
                        set_target(12'($urandom), 12'($urandom),
                                   12'($urandom_range(1, 600)),
                                   12'($urandom_range(1, 600)));
                end
            endcase
            rx_throttle = (phase % 3 != 0);
            phase_sent = 0;
            while (phase_sent < 105) begin
                k = $urandom_range(0, 19);
                set_len = (k < 14) ? $urandom_range(1, 6) :
                          (k < 19) ? $urandom_range(7, 20) : $urandom_range(21, 60);
                for (int j = 0; j < set_len; j++) begin
                    k = $urandom_range(0, 9);
                    if (k < 6) begin
                        c = near_target();
                    end else if (k == 6) begin
                        c = prev;
                        c.score = 16'($urandom);
                    end else if (k == 7) begin
                        c = {12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                             16'($urandom), 1'b0};
                        if (c.right > c.left)
                            {c.left, c.right} = {c.right, c.left};
                    end else begin
                        c = {12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                             16'($urandom), 1'b0};
                    end
                    c.last = (j == set_len - 1);
                    send_box(c, pick_gap(), 0, '0);
                    prev = c;
                end
                phase_sent += set_len;
                // sender holds off until the block has delivered everything
                if (phase == 5 && phase_sent > 50 && phase_sent - set_len <= 50)
                    drain_results();
            end
            sent += phase_sent;
            phase++;
        end

        drain_results();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
